// ===== design/rsmv_pkg.sv =====
`timescale 1ns / 1ps
package rsmv_pkg;

	localparam int MAX_SIDE         = 512;
	localparam int WEIGHT_FRAC_BITS = 16;

	localparam int COORD_W  = 9;
	localparam int SIDE_W   = 10;
	localparam int RADIUS_W = 15;
	localparam int DATA_W   = 16;
	localparam int INDEX_W  = 2;
	localparam int WEIGHT_W = WEIGHT_FRAC_BITS + 1;

	localparam int RATIO_W  = 24;
	localparam int POWER_W  = 51;
	localparam int RECIP_K  = 2 * WEIGHT_FRAC_BITS + 18;
	localparam int QUOT_W   = RECIP_K - 16 + 1;
	localparam int ROOT_W   = (QUOT_W + 1) / 2;

	localparam int RATIO_LAT = 4 + RATIO_W;
	localparam int POWER_LAT = 6;
	localparam int RECIP_LAT = QUOT_W;
	localparam int SQRT_LAT  = ROOT_W;
	localparam int PIPE_LAT  = RATIO_LAT + POWER_LAT + RECIP_LAT + SQRT_LAT + 1;

	localparam logic [INDEX_W-1:0] REG_GRID_SIDE = 2'd0;
	localparam logic [INDEX_W-1:0] REG_RADIUS    = 2'd1;

	localparam logic [SIDE_W-1:0]   SIDE_RESET   = 10'd256;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd6400;

	// valid bit and forced-zero flag travelling with each voxel
	typedef struct packed {
		logic valid;
		logic sat;
	} ctl_t;

endpackage

// ===== design/radial_soft_mask_voxel_unit.sv =====
`timescale 1ns / 1ps
// soft spherical mask: one voxel request (x, y, z) is taken every clock while
// start is high, busy never rises, and each voxel's weight 1/sqrt(1+(d2/R2)^8)
// appears on mask_weight with done high for one cycle, in request order. the
// receiver cannot stall the result. the pipeline is built from the bit-per-stage
// chains: 24 stages of the ratio divider, 35 stages of the reciprocal divider and
// 18 stages of the square root, plus the offset, squaring and rounding stages
// around them.
// grid_side and radius_q6 are written through the cfg port (always ready);
// write them only while no voxel is in flight. a zero radius, a ratio of 256
// or more or an overflow of the eighth power gives weight 0.
module radial_soft_mask_voxel_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [rsmv_pkg::COORD_W-1:0]   x_index,
	input  logic [rsmv_pkg::COORD_W-1:0]   y_index,
	input  logic [rsmv_pkg::COORD_W-1:0]   z_index,
	output logic                           done,
	output logic [rsmv_pkg::WEIGHT_W-1:0]  mask_weight,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rsmv_pkg::INDEX_W-1:0]   cfg_index,
	input  logic [rsmv_pkg::DATA_W-1:0]    cfg_data
);
	import rsmv_pkg::*;

	logic [SIDE_W-1:0]   grid_side_q;
	logic [RADIUS_W-1:0] radius_q;
	logic                accept;

	ctl_t                ratio_ctl, power_ctl, recip_ctl, root_ctl;
	logic [RATIO_W-1:0]  ratio;
	logic [POWER_W-1:0]  power;
	logic [QUOT_W-1:0]   quot;
	logic [ROOT_W-1:0]   root;
	logic [ROOT_W:0]     root_rnd;

	logic                done_q;
	logic [WEIGHT_W-1:0] weight_q;

	// fully pipelined, so a request is never refused
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	// register file; writes beyond the list fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= SIDE_RESET;
			radius_q    <= RADIUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GRID_SIDE: grid_side_q <= cfg_data[SIDE_W-1:0];
				REG_RADIUS:    radius_q    <= cfg_data[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// offsets, squared distance and the q8.16 ratio d2/R2
	rsmv_ratio u_ratio (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.x_in     (x_index),
		.y_in     (y_index),
		.z_in     (z_index),
		.side     (grid_side_q),
		.radius   (radius_q),
		.out_ctl  (ratio_ctl),
		.ratio    (ratio)
	);

	// 1 + ratio^8 through three rounded squarings
	rsmv_power u_power (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (ratio_ctl),
		.ratio   (ratio),
		.out_ctl (power_ctl),
		.power   (power)
	);

	// 2^50 / power, which is 2^34 / (1 + ratio^8) as an integer
	rsmv_recip u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (power_ctl),
		.power   (power),
		.out_ctl (recip_ctl),
		.quot    (quot)
	);

	// floor square root gives twice the weight, to one extra bit
	rsmv_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (recip_ctl),
		.quot    (quot),
		.out_ctl (root_ctl),
		.root    (root)
	);

	// halve with rounding to nearest, ties up
	assign root_rnd = {1'b0, root} + (ROOT_W + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= root_ctl.valid;
		end
	end

	// saturated voxels (zero radius, ratio or power overflow) are forced to zero
	always_ff @(posedge clk) begin
		weight_q <= root_ctl.sat ? '0 : root_rnd[WEIGHT_W:1];
	end

	assign done        = done_q;
	assign mask_weight = weight_q;

`ifndef ASSERT_OFF
	// every result goes back to a matching earlier request
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_LAT))
		else $error("result without matching request");

	// weight never goes above 1.0
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (mask_weight <= WEIGHT_W'(65536)))
		else $error("mask weight above one");

	// a zero radius at the front marks the voxel as forced zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(ratio_ctl.valid && $past(radius_q == '0, RATIO_LAT)
			&& $stable(radius_q)) |-> ratio_ctl.sat)
		else $error("zero radius not flagged");

	// the valid bit leaves the square root stage in the cycle before done
	assert property (@(posedge clk) disable iff (!arst_n)
		root_ctl.valid |=> done)
		else $error("result strobe lost");
`endif

endmodule

// ===== design/rsmv_ratio.sv =====
`timescale 1ns / 1ps
module rsmv_ratio (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [rsmv_pkg::COORD_W-1:0]   x_in,
	input  logic [rsmv_pkg::COORD_W-1:0]   y_in,
	input  logic [rsmv_pkg::COORD_W-1:0]   z_in,
	input  logic [rsmv_pkg::SIDE_W-1:0]    side,
	input  logic [rsmv_pkg::RADIUS_W-1:0]  radius,
	output rsmv_pkg::ctl_t                 out_ctl,
	output logic [rsmv_pkg::RATIO_W-1:0]   ratio
);
	import rsmv_pkg::*;

	localparam int NUM_W = 55;
	localparam int DEN_W = 31;

	function automatic logic [SIDE_W-1:0] abs_off(input logic [COORD_W-1:0] c,
			input logic [SIDE_W-1:0] s);
		logic [SIDE_W-1:0] twice;
		twice = {c, 1'b0};
		return (twice >= s) ? twice - s : s - twice;
	endfunction

	logic [SIDE_W-1:0]   side_sat;
	logic [SIDE_W-1:0]   dx_s1, dy_s1, dz_s1;
	logic [RADIUS_W-1:0] r_s1;
	ctl_t                ctl_s1, ctl_s2, ctl_s3;
	logic [19:0]         sqx_s2, sqy_s2, sqz_s2;
	logic [29:0]         r2_s2, r2_s3;
	logic [21:0]         d4_s3;
	logic [NUM_W-1:0]    num_c;
	logic [DEN_W-1:0]    den_c;

	logic [NUM_W-1:0]    rem_s [0:RATIO_W];
	logic [RATIO_W-1:0]  quo_s [0:RATIO_W];
	logic [DEN_W-1:0]    den_s [0:RATIO_W];
	ctl_t                ctl_s [0:RATIO_W];

	assign side_sat = (side > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side;
	assign num_c    = {d4_s3, 27'd0} + NUM_W'(r2_s3);
	assign den_c    = {r2_s3, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			ctl_s2   <= '0;
			ctl_s3   <= '0;
			ctl_s[0] <= '0;
		end else begin
			ctl_s1       <= '{valid: in_valid, sat: (radius == '0)};
			ctl_s2       <= ctl_s1;
			ctl_s3       <= ctl_s2;
			ctl_s[0].valid <= ctl_s3.valid;
			// ratio of 256 or more leaves the q8.16 range
			ctl_s[0].sat <= ctl_s3.sat | (num_c >= {den_c, 24'd0});
		end
	end

	always_ff @(posedge clk) begin
		dx_s1    <= abs_off(x_in, side_sat);
		dy_s1    <= abs_off(y_in, side_sat);
		dz_s1    <= abs_off(z_in, side_sat);
		r_s1     <= radius;
		sqx_s2   <= dx_s1 * dx_s1;
		sqy_s2   <= dy_s1 * dy_s1;
		sqz_s2   <= dz_s1 * dz_s1;
		r2_s2    <= r_s1 * r_s1;
		d4_s3    <= 22'(sqx_s2) + 22'(sqy_s2) + 22'(sqz_s2);
		r2_s3    <= r2_s2;
		rem_s[0] <= num_c;
		den_s[0] <= den_c;
		quo_s[0] <= '0;
	end

	// one quotient bit per stage, msb first
	for (genvar g = 0; g < RATIO_W; g++) begin : g_div
		logic [NUM_W-1:0] trial;
		logic             take;
		assign trial = NUM_W'(den_s[g]) << (RATIO_W - 1 - g);
		assign take  = rem_s[g] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[g+1] <= '0;
			end else begin
				ctl_s[g+1] <= ctl_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= take ? rem_s[g] - trial : rem_s[g];
			quo_s[g+1] <= {quo_s[g][RATIO_W-2:0], take};
			den_s[g+1] <= den_s[g];
		end
	end

	assign out_ctl = ctl_s[RATIO_W];
	assign ratio   = quo_s[RATIO_W];

endmodule

// ===== design/rsmv_power.sv =====
`timescale 1ns / 1ps
module rsmv_power (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rsmv_pkg::ctl_t                in_ctl,
	input  logic [rsmv_pkg::RATIO_W-1:0]  ratio,
	output rsmv_pkg::ctl_t                out_ctl,
	output logic [rsmv_pkg::POWER_W-1:0]  power
);
	import rsmv_pkg::*;

	ctl_t        ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic [47:0] sq1_s1;
	logic [24:0] s1_s2;
	logic [49:0] sq2_s3;
	logic [32:0] s2_s4;
	logic [33:0] hh_s5;
	logic [32:0] hl_s5;
	logic [31:0] ll_s5;
	logic [POWER_W-1:0] p_s6;

	logic [47:0] sum1;
	logic [49:0] sum2;
	logic [32:0] ll_rnd;

	assign sum1   = sq1_s1 + 48'd32768;
	assign sum2   = sq2_s3 + 50'd32768;
	assign ll_rnd = 33'(ll_s5) + 33'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else begin
			ctl_s1       <= in_ctl;
			ctl_s2.valid <= ctl_s1.valid;
			ctl_s2.sat   <= ctl_s1.sat | (|sum1[47:41]);
			ctl_s3       <= ctl_s2;
			ctl_s4.valid <= ctl_s3.valid;
			ctl_s4.sat   <= ctl_s3.sat | sum2[49];
			ctl_s5       <= ctl_s4;
			ctl_s6       <= ctl_s5;
		end
	end

	// three rounded q.16 squarings, the last one split into partial products
	always_ff @(posedge clk) begin
		sq1_s1 <= ratio * ratio;
		s1_s2  <= sum1[40:16];
		sq2_s3 <= s1_s2 * s1_s2;
		s2_s4  <= sum2[48:16];
		hh_s5  <= s2_s4[32:16] * s2_s4[32:16];
		hl_s5  <= s2_s4[32:16] * s2_s4[15:0];
		ll_s5  <= s2_s4[15:0] * s2_s4[15:0];
		p_s6   <= POWER_W'(65536) + POWER_W'({hh_s5, 16'd0})
			+ POWER_W'({hl_s5, 1'b0}) + POWER_W'(ll_rnd[32:16]);
	end

	assign out_ctl = ctl_s6;
	assign power   = p_s6;

endmodule

// ===== design/rsmv_recip.sv =====
`timescale 1ns / 1ps
module rsmv_recip (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rsmv_pkg::ctl_t                in_ctl,
	input  logic [rsmv_pkg::POWER_W-1:0]  power,
	output rsmv_pkg::ctl_t                out_ctl,
	output logic [rsmv_pkg::QUOT_W-1:0]   quot
);
	import rsmv_pkg::*;

	// leading dividend bits never reach the divisor (power >= 2^16)
	logic [POWER_W-1:0] rem_s [0:QUOT_W];
	logic [QUOT_W-1:0]  quo_s [0:QUOT_W];
	logic [POWER_W-1:0] div_s [0:QUOT_W];
	ctl_t               ctl_s [0:QUOT_W];

	assign rem_s[0] = POWER_W'(32768);
	assign quo_s[0] = '0;
	assign div_s[0] = power;
	assign ctl_s[0] = in_ctl;

	for (genvar g = 0; g < QUOT_W; g++) begin : g_div
		logic [POWER_W:0] sh;
		logic [POWER_W:0] diff;
		logic             take;
		assign sh   = {rem_s[g], 1'b0};
		assign diff = sh - {1'b0, div_s[g]};
		assign take = sh >= {1'b0, div_s[g]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[g+1] <= '0;
			end else begin
				ctl_s[g+1] <= ctl_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= take ? diff[POWER_W-1:0] : sh[POWER_W-1:0];
			quo_s[g+1] <= {quo_s[g][QUOT_W-2:0], take};
			div_s[g+1] <= div_s[g];
		end
	end

	assign out_ctl = ctl_s[QUOT_W];
	assign quot    = quo_s[QUOT_W];

endmodule

// ===== design/rsmv_sqrt.sv =====
`timescale 1ns / 1ps
module rsmv_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rsmv_pkg::ctl_t               in_ctl,
	input  logic [rsmv_pkg::QUOT_W-1:0]  quot,
	output rsmv_pkg::ctl_t               out_ctl,
	output logic [rsmv_pkg::ROOT_W-1:0]  root
);
	import rsmv_pkg::*;

	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	logic [RAD_W-1:0]  rad_s  [0:ROOT_W];
	logic [REM_W-1:0]  rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	ctl_t              ctl_s  [0:ROOT_W];

	assign rad_s[0]  = RAD_W'(quot);
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign ctl_s[0]  = in_ctl;

	// one root bit per stage, two radicand bits brought down each time
	for (genvar g = 0; g < ROOT_W; g++) begin : g_root
		logic [REM_W+1:0] sh;
		logic [REM_W+1:0] t;
		logic [REM_W+1:0] diff;
		logic             take;
		assign sh   = {rem_s[g], rad_s[g][RAD_W-1-2*g -: 2]};
		assign t    = (REM_W + 2)'({root_s[g], 2'b01});
		assign diff = sh - t;
		assign take = sh >= t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[g+1] <= '0;
			end else begin
				ctl_s[g+1] <= ctl_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= take ? diff[REM_W-1:0] : sh[REM_W-1:0];
			root_s[g+1] <= {root_s[g][ROOT_W-2:0], take};
			rad_s[g+1]  <= rad_s[g];
		end
	end

	assign out_ctl = ctl_s[ROOT_W];
	assign root    = root_s[ROOT_W];

endmodule
